[sv/life_generation_stream_core_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the life generation stream core
// Shared property forms used by the top level's checks.
// -----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STREAM_CORE_MACROS_SVH
`define LIFE_GENERATION_STREAM_CORE_MACROS_SVH

// same-cycle implication
`define LGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgs: same-cycle check failed");

// next-cycle implication
`define LGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgs: next-cycle check failed");

`endif

[sv/lgs_pkg.sv]
// -----------------------------------------------------------------------------
// lgs_pkg
// Types, constants and helpers shared by the life generation stream core.
// -----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int GRID_W          = 11;
  localparam int COLOR_W         = 32;
  localparam int GEN_W           = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [GRID_W-1:0]  GRID_RESET   = 11'd1024;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 32'hFFFF_00FF;
  localparam logic [GEN_W-1:0]   MAXGEN_RESET = 16'd1;
  localparam logic [GEN_W-1:0]   GEN_SAT      = 16'hFFFF;
  localparam int                 GRID_MIN     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIVE_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GEN    = 2'd2;

  // per-item decode handed from front to back
  typedef struct packed {
    logic ra;     // row above exists
    logic rb;     // two rows above exist
    logic live;   // incoming cell live
    logic match;  // incoming pixel equals live colour
    logic drain;  // drain item, no store write
    logic emit;   // item releases a result
    logic last;   // result closes the frame
    logic col0;   // column 0: right column is off-grid
    logic col1;   // column 1: left column is off-grid
  } lgs_flags_t;

  localparam int FLAGS_W = $bits(lgs_flags_t);

  function automatic logic [1:0] pop3(input logic [2:0] v);
    pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

endpackage

[sv/life_generation_stream_core.sv]
// Order: a cell's result is released by a later item, which passes the queue, the store
//   read and the output register; that item comes grid_size+1 items after the cell itself.
// Throughput: one item per cycle unless out_ready stalls, set by the line store (a read and a write per cycle).
// Reset: control state clears at once, then a pass over all MAX_DIM store entries zeroes the
//   line stores; in_ready stays low during the pass, configuration writes are taken throughout.
// -----------------------------------------------------------------------------
// life_generation_stream_core
// Streams one B3/S23 generation of a square grid in raster order.
// -----------------------------------------------------------------------------
`include "life_generation_stream_core_macros.svh"

module life_generation_stream_core #(
  parameter int MAX_DIM = lgs_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [31:0]                    pixel,
  // results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    cell_value,
  output logic                           changed,
  output logic                           frame_last,
  output logic                           frame_stable,
  output logic                           run_done,
  output logic [15:0]                    generations_taken,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import lgs_pkg::*;

  localparam int AW = $clog2(MAX_DIM);

  // configuration registers
  logic [GRID_W-1:0]  grid_size;
  logic [COLOR_W-1:0] live_color;
  logic [GEN_W-1:0]   max_generations;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size       <= GRID_RESET;
      live_color      <= COLOR_RESET;
      max_generations <= MAXGEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_SIZE:  grid_size       <= cfg_data[GRID_W-1:0];
        REG_LIVE_COLOR: live_color      <= cfg_data;
        REG_MAX_GEN:    max_generations <= cfg_data[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking and item decode
  logic          push_valid, q_not_full, q_not_empty, q_pop, clear_busy;
  logic [AW-1:0] push_col, q_col;
  lgs_flags_t    push_flags, q_flags;

  lgs_front #(.MAX_DIM(MAX_DIM), .AW(AW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pixel      (pixel),
    .grid_size  (grid_size),
    .live_color (live_color),
    .hold       (clear_busy),
    .push_ready (q_not_full),
    .push_valid (push_valid),
    .push_col   (push_col),
    .push_flags (push_flags)
  );

  // decoupling queue: each transfer carries column plus decode flags
  logic [AW+FLAGS_W-1:0] q_head;

  lgs_queue #(.W(AW + FLAGS_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data ({push_col, push_flags}),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  assign q_col   = q_head[AW+FLAGS_W-1:FLAGS_W];
  assign q_flags = lgs_flags_t'(q_head[FLAGS_W-1:0]);

  // back: line stores, window, rule, frame statistics
  lgs_back #(.MAX_DIM(MAX_DIM), .AW(AW)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_not_empty),
    .q_col             (q_col),
    .q_flags           (q_flags),
    .q_pop             (q_pop),
    .live_color        (live_color),
    .max_generations   (max_generations),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cell_value        (cell_value),
    .changed           (changed),
    .frame_last        (frame_last),
    .frame_stable      (frame_stable),
    .run_done          (run_done),
    .generations_taken (generations_taken)
  );

  // checks
  `LGS_ASSERT_IMPL(a_no_in_while_clear, clk, rst, clear_busy, !in_ready)
  `LGS_ASSERT_IMPL(a_done_only_on_last, clk, rst, out_valid && !frame_last,
                   !run_done && !frame_stable && generations_taken == 16'd0)
  `LGS_ASSERT_IMPL(a_stable_ends_run, clk, rst, out_valid && frame_stable, run_done)
  `LGS_ASSERT_IMPL(a_unstable_takes_zero, clk, rst, out_valid && !frame_stable,
                   generations_taken == 16'd0)

endmodule

[sv/lgs_front.sv]
// -----------------------------------------------------------------------------
// lgs_front
// Accepts items, tracks row/column position and classifies each transfer.
// -----------------------------------------------------------------------------
module lgs_front #(
  parameter int MAX_DIM = lgs_pkg::MAX_DIM_DEFAULT,
  parameter int AW      = $clog2(MAX_DIM)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [31:0]                 pixel,
  input  logic [lgs_pkg::GRID_W-1:0]  grid_size,
  input  logic [lgs_pkg::COLOR_W-1:0] live_color,
  input  logic                        hold,
  input  logic                        push_ready,
  output logic                        push_valid,
  output logic [AW-1:0]               push_col,
  output lgs_pkg::lgs_flags_t         push_flags
);
  import lgs_pkg::*;

  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int GW = (NW > GRID_W) ? NW + 1 : GRID_W + 1;

  logic [AW-1:0] column_count;
  logic [NW-1:0] row_count;
  logic          tail_pending;

  logic [GW-1:0] grid_ext, n;
  logic [AW-1:0] c;
  logic [NW-1:0] r;
  logic          accept, drain, skip, in_grid, last, emit;
  logic [31:0]   eff;

  always_comb begin
    grid_ext = GW'(grid_size);
    if (grid_ext < GW'(GRID_MIN)) n = GW'(GRID_MIN);
    else if (grid_ext > GW'(MAX_DIM)) n = GW'(MAX_DIM);
    else n = grid_ext;
    c = (GW'(column_count) >= GW'(MAX_DIM)) ? '0 : column_count;
    r = row_count;
    drain   = (r == '0) && (c == '0) && kind;
    skip    = drain && !tail_pending;
    in_grid = GW'(r) < n;
    eff     = (!drain && in_grid && !kind) ? pixel : 32'd0;
    if (c == '0) begin
      emit = (r >= NW'(2)) || tail_pending;
      last = tail_pending && (r == '0);
    end else begin
      emit = (r >= NW'(1));
      last = 1'b0;
    end
  end

  assign in_ready   = push_ready && !hold;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && !skip;
  assign push_col   = c;

  always_comb begin
    push_flags.ra    = r >= NW'(1);
    push_flags.rb    = r >= NW'(2);
    push_flags.live  = eff != 32'd0;
    push_flags.match = eff == live_color;
    push_flags.drain = drain;
    push_flags.emit  = emit;
    push_flags.last  = last;
    push_flags.col0  = c == '0;
    push_flags.col1  = c == AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      tail_pending <= 1'b0;
    end else if (accept) begin
      if (last || drain) tail_pending <= 1'b0;
      if (!drain) begin
        if (GW'(c) + GW'(1) >= n) begin
          column_count <= '0;
          if (!in_grid) begin
            row_count    <= '0;
            tail_pending <= 1'b1;
          end else begin
            row_count <= r + NW'(1);
          end
        end else begin
          column_count <= c + AW'(1);
        end
      end
    end
  end

endmodule

[sv/lgs_queue.sv]
// -----------------------------------------------------------------------------
// lgs_queue
// Two-entry queue between front and back.
// -----------------------------------------------------------------------------
module lgs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  output logic         not_empty,
  input  logic         pop,
  output logic [W-1:0] head
);
  logic [W-1:0] slot [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign not_full  = count != 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/lgs_back.sv]
// -----------------------------------------------------------------------------
// lgs_back
// Line stores, 3x3 window, rule evaluation, frame statistics, output register.
// -----------------------------------------------------------------------------
module lgs_back #(
  parameter int MAX_DIM = lgs_pkg::MAX_DIM_DEFAULT,
  parameter int AW      = $clog2(MAX_DIM)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  logic [AW-1:0]               q_col,
  input  lgs_pkg::lgs_flags_t         q_flags,
  output logic                        q_pop,
  input  logic [lgs_pkg::COLOR_W-1:0] live_color,
  input  logic [lgs_pkg::GEN_W-1:0]   max_generations,
  output logic                        clear_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 cell_value,
  output logic                        changed,
  output logic                        frame_last,
  output logic                        frame_stable,
  output logic                        run_done,
  output logic [15:0]                 generations_taken
);
  import lgs_pkg::*;

  // [1:0] upper line {match, live}, [3:2] line two rows up
  logic [3:0] row_store [MAX_DIM];
  logic [3:0] rdata;
  logic [AW-1:0] clear_addr;

  logic          b1_valid;
  logic [AW-1:0] b1_col;
  lgs_flags_t    b1_flags;

  logic [8:0]       window;
  // match bit of the window's right column; it becomes the centre's on the next shift
  logic             right_match;
  logic             frame_unchanged;
  logic [GEN_W-1:0] generation_count;

  logic             out_free, fire, mem_we;
  logic [AW-1:0]    mem_wa;
  logic [3:0]       mem_wd;
  logic [1:0]       a, b;
  logic [8:0]       window_next;
  logic [2:0]       lcol, mcol, rcol;
  logic [2:0]       count;
  logic             next_live, chg, stable, done;
  logic [GEN_W-1:0] g;

  assign out_free = !out_valid || out_ready;
  assign fire     = b1_valid && out_free;
  assign q_pop    = q_valid && (!b1_valid || fire);

  always_comb begin
    a = b1_flags.ra ? rdata[1:0] : 2'b00;
    b = b1_flags.rb ? rdata[3:2] : 2'b00;
    window_next = {b1_flags.live, a[0], b[0], window[8:3]};
    lcol = window_next[2:0];
    mcol = window_next[5:3];
    rcol = window_next[8:6];
    if (b1_flags.col0) rcol = 3'b000;
    else if (b1_flags.col1) lcol = 3'b000;
    count = {1'b0, pop3(lcol)} + {1'b0, pop3(rcol)} + {2'b00, mcol[0]} + {2'b00, mcol[2]};
    next_live = (count == 3'd3) || (mcol[1] && count == 3'd2);
    chg       = next_live ? !right_match : mcol[1];
    stable    = frame_unchanged && !chg;
    g         = (generation_count < GEN_SAT) ? generation_count + GEN_W'(1) : generation_count;
    done      = stable || (g >= max_generations);
  end

  assign mem_we = clear_busy || (fire && !b1_flags.drain);
  assign mem_wa = clear_busy ? clear_addr : b1_col;
  assign mem_wd = clear_busy ? 4'b0000 : {a, b1_flags.match, b1_flags.live};

  always_ff @(posedge clk) begin
    if (mem_we) row_store[mem_wa] <= mem_wd;
    if (q_pop)  rdata <= row_store[q_col];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_col   <= q_col;
      b1_flags <= q_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && b1_flags.emit) begin
      cell_value        <= next_live ? live_color : 32'd0;
      changed           <= chg;
      frame_last        <= b1_flags.last;
      frame_stable      <= b1_flags.last && stable;
      run_done          <= b1_flags.last && done;
      generations_taken <= (b1_flags.last && done && stable) ? g : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy       <= 1'b1;
      clear_addr       <= '0;
      b1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      window           <= '0;
      right_match      <= 1'b0;
      frame_unchanged  <= 1'b1;
      generation_count <= '0;
    end else begin
      if (clear_busy) begin
        clear_addr <= clear_addr + AW'(1);
        if (clear_addr == AW'(MAX_DIM - 1)) clear_busy <= 1'b0;
      end
      if (q_pop) b1_valid <= 1'b1;
      else if (fire) b1_valid <= 1'b0;
      if (fire && b1_flags.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) begin
        window      <= window_next;
        right_match <= a[1];
        if (b1_flags.emit) begin
          if (b1_flags.last) begin
            frame_unchanged  <= 1'b1;
            generation_count <= done ? '0 : g;
          end else if (chg) begin
            frame_unchanged <= 1'b0;
          end
        end
      end
    end
  end

endmodule
